// ===== hw/rtl/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle tracker package
// Shared widths, action codes and the stored rectangle type.
// ----------------------------------------------------------------------------
package drt_pkg;

    // Input coordinates are 13-bit pixels; edges carry one extra bit for x + w.
    localparam int COORD_W = 13;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int COUNT_OUT_W = 5;

    // Action codes of an input beat.
    localparam logic [2:0] ACT_MARK       = 3'd0;
    localparam logic [2:0] ACT_CHECK      = 3'd1;
    localparam logic [2:0] ACT_INVALIDATE = 3'd2;
    localparam logic [2:0] ACT_INIT       = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;

    // One rectangle as left, top, right and bottom edges (56 bits).
    typedef struct packed {
        logic [EDGE_W-1:0] l;
        logic [EDGE_W-1:0] t;
        logic [EDGE_W-1:0] r;
        logic [EDGE_W-1:0] b;
    } box_t;

    localparam int BOX_W = $bits(box_t);

endpackage

// ===== hw/rtl/dirty_rectangle_tracker.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle tracker
// Keeps a bounded list of dirty rectangles, merges touching marks into it
// and answers whether a rectangle needs drawing.
//
// Channel   Direction  Handshake              Beat
// command   in         start & !busy          action, rect_x/y/width/height
// result    out        done (one cycle)       needs_draw, full_redraw_pending,
//                                             region_count
// config    in         cfg_valid & cfg_ready  cfg_data (tracking enable)
//
// Each region-table entry visit is a RAM read, then a compare in the shared
// box unit; an absorbed entry that must be refilled from the list's tail
// adds a tail read and a write, and the scan then restarts at entry zero.
// A check stops at the first touching entry or after the last; a mark that
// is not ignored ends with an append step. Reset clears the count, sets the
// full redraw flag and turns tracking off; the table needs no clearing pass.
// Results cannot be stalled; busy falls in the cycle that carries the result
// beat.
// ----------------------------------------------------------------------------
module dirty_rectangle_tracker #(
    parameter int MAX_REGIONS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command channel.
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    action,
    input  logic [drt_pkg::COORD_W-1:0]   rect_x,
    input  logic [drt_pkg::COORD_W-1:0]   rect_y,
    input  logic [drt_pkg::COORD_W-1:0]   rect_width,
    input  logic [drt_pkg::COORD_W-1:0]   rect_height,
    // Result channel.
    output logic                          done,
    output logic                          needs_draw,
    output logic                          full_redraw_pending,
    output logic [drt_pkg::COUNT_OUT_W-1:0] region_count,
    // Configuration channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MREAD,
        S_MWRITE,
        S_APPEND,
        S_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    drt_pkg::box_t                   box_reg, box_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            flag_reg, flag_next;
    logic                            enabled_reg, enabled_next;
    logic                            check_reg, check_next;
    logic                            need_reg, need_next;
    logic                            done_reg, done_next;
    logic                            needs_draw_reg, needs_draw_next;
    logic                            frp_reg, frp_next;
    logic [drt_pkg::COUNT_OUT_W-1:0] rcount_reg, rcount_next;

    drt_pkg::box_t                   in_box;
    drt_pkg::box_t                   entry_box;
    drt_pkg::box_t                   merged_box;
    logic                            touch;
    logic [CNT_W-1:0]                idx_ext;
    logic [CNT_W-1:0]                idx_inc;
    logic [CNT_W-1:0]                count_dec;

    logic                            ram_wr_en;
    logic [IDX_W-1:0]                ram_wr_addr;
    logic [drt_pkg::BOX_W-1:0]       ram_wr_data;
    logic [IDX_W-1:0]                ram_rd_addr;
    logic [drt_pkg::BOX_W-1:0]       ram_rd_data;

    // Edges of the incoming rectangle.
    always_comb
    begin
        in_box.l = {1'b0, rect_x};
        in_box.t = {1'b0, rect_y};
        in_box.r = {1'b0, rect_x} + {1'b0, rect_width};
        in_box.b = {1'b0, rect_y} + {1'b0, rect_height};
    end

    assign entry_box = drt_pkg::box_t'(ram_rd_data);
    assign idx_ext   = CNT_W'(idx_reg);
    assign idx_inc   = idx_ext + 1'b1;
    assign count_dec = count_reg - 1'b1;

    // Region table storage.
    drt_ram #(
        .WIDTH (drt_pkg::BOX_W),
        .DEPTH (MAX_REGIONS),
        .ADDR_W(IDX_W)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // Shared compare and merge unit, fed one table entry per visit.
    drt_box_unit u_box (
        .a     (entry_box),
        .b     (box_reg),
        .touch (touch),
        .merged(merged_box)
    );

    // RAM port selection: tail read during a refill, table writes on refill
    // and append.
    always_comb
    begin
        ram_rd_addr = (state_reg == S_MREAD) ? count_reg[IDX_W-1:0] : idx_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = ram_rd_data;
        if (state_reg == S_MWRITE)
        begin
            ram_wr_en = 1'b1;
        end
        else if ((state_reg == S_APPEND) && (count_reg < CNT_MAX))
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_reg[IDX_W-1:0];
            ram_wr_data = box_reg;
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        box_next        = box_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        flag_next       = flag_reg;
        enabled_next    = enabled_reg;
        check_next      = check_reg;
        need_next       = need_reg;
        done_next       = 1'b0;
        needs_draw_next = needs_draw_reg;
        frp_next        = frp_reg;
        rcount_next     = rcount_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    box_next   = in_box;
                    check_next = (action == drt_pkg::ACT_CHECK);
                    idx_next   = '0;
                    need_next  = 1'b0;
                    state_next = S_FINISH;
                    case (action)
                        drt_pkg::ACT_MARK:
                        begin
                            if (enabled_reg && !flag_reg)
                            begin
                                state_next = (count_reg == '0) ? S_APPEND : S_READ;
                            end
                        end
                        drt_pkg::ACT_CHECK:
                        begin
                            if (!enabled_reg || flag_reg)
                            begin
                                need_next = 1'b1;
                            end
                            else if (count_reg != '0)
                            begin
                                state_next = S_READ;
                            end
                        end
                        drt_pkg::ACT_INVALIDATE:
                        begin
                            flag_next = 1'b1;
                        end
                        drt_pkg::ACT_INIT:
                        begin
                            count_next   = '0;
                            flag_next    = 1'b1;
                            enabled_next = 1'b0;
                        end
                        drt_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            flag_next  = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_CMP;
            end

            // Compare the entry just read against the working rectangle.
            S_CMP:
            begin
                if (touch)
                begin
                    if (check_reg)
                    begin
                        need_next  = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        box_next   = merged_box;
                        count_next = count_dec;
                        if (idx_ext == count_dec)
                        begin
                            // The absorbed entry was the tail: nothing to move.
                            idx_next   = '0;
                            state_next = (idx_reg == '0) ? S_APPEND : S_READ;
                        end
                        else
                        begin
                            state_next = S_MREAD;
                        end
                    end
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = check_reg ? S_FINISH : S_APPEND;
                end
                else
                begin
                    idx_next   = idx_inc[IDX_W-1:0];
                    state_next = S_READ;
                end
            end

            S_MREAD:
            begin
                state_next = S_MWRITE;
            end

            // Tail entry lands in the freed slot; rescan from the start.
            S_MWRITE:
            begin
                idx_next   = '0;
                state_next = S_READ;
            end

            S_APPEND:
            begin
                if (count_reg < CNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    flag_next = 1'b1;
                end
                state_next = S_FINISH;
            end

            // Present the result beat for one cycle.
            S_FINISH:
            begin
                done_next       = 1'b1;
                needs_draw_next = need_reg;
                frp_next        = flag_reg;
                rcount_next     = drt_pkg::COUNT_OUT_W'(count_reg);
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration write: enabling tracking forces a full redraw.
        if (cfg_valid && cfg_ready)
        begin
            enabled_next = cfg_data;
            if (cfg_data)
            begin
                flag_next = 1'b1;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            box_reg        <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            flag_reg       <= 1'b1;
            enabled_reg    <= 1'b0;
            check_reg      <= 1'b0;
            need_reg       <= 1'b0;
            done_reg       <= 1'b0;
            needs_draw_reg <= 1'b0;
            frp_reg        <= 1'b0;
            rcount_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            box_reg        <= box_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            flag_reg       <= flag_next;
            enabled_reg    <= enabled_next;
            check_reg      <= check_next;
            need_reg       <= need_next;
            done_reg       <= done_next;
            needs_draw_reg <= needs_draw_next;
            frp_reg        <= frp_next;
            rcount_reg     <= rcount_next;
        end
    end

    // Configuration is taken only while idle and no command is arriving.
    assign busy                = (state_reg != S_IDLE);
    assign cfg_ready           = (state_reg == S_IDLE) && !start;
    assign done                = done_reg;
    assign needs_draw          = needs_draw_reg;
    assign full_redraw_pending = frp_reg;
    assign region_count        = rcount_reg;

endmodule

// ===== hw/rtl/drt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module drt_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/drt_box_unit.sv =====
// ----------------------------------------------------------------------------
// Rectangle compare and merge unit
// Tells whether two rectangles touch and forms their bounding union.
// ----------------------------------------------------------------------------
module drt_box_unit (
    input  drt_pkg::box_t a,
    input  drt_pkg::box_t b,
    output logic          touch,
    output drt_pkg::box_t merged
);

    // Touching edges count as an intersection.
    assign touch = !((a.r < b.l) || (b.r < a.l) || (a.b < b.t) || (b.b < a.t));

    // Bounding box of both rectangles.
    always_comb
    begin
        merged.l = (a.l < b.l) ? a.l : b.l;
        merged.t = (a.t < b.t) ? a.t : b.t;
        merged.r = (a.r > b.r) ? a.r : b.r;
        merged.b = (a.b > b.b) ? a.b : b.b;
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle tracker testbench
// Drives mark, check, invalidate, init and clear commands into the tracker,
// predicts each result beat from a behavioral copy of the region list, and
// compares every field of every result beat. A short directed section covers
// the gating rules, edge extremes and merging; random phases then exercise
// clustered merges, list overflow and full-range coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int DIRTY_SLOTS = 16;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [drt_pkg::COORD_W-1:0] COORD_MAX = '1;

    // Action codes the tracker ignores.
    localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
    localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

    typedef enum int {PLACE_CLUSTER, PLACE_GRID, PLACE_WIDE} place_mode_t;

    typedef struct {
        logic                            needs_draw;
        logic                            redraw_all;
        logic [drt_pkg::COUNT_OUT_W-1:0] count;
    } tracker_status_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [2:0]                      action;
    logic [drt_pkg::COORD_W-1:0]     rect_x;
    logic [drt_pkg::COORD_W-1:0]     rect_y;
    logic [drt_pkg::COORD_W-1:0]     rect_width;
    logic [drt_pkg::COORD_W-1:0]     rect_height;
    logic                            done;
    logic                            needs_draw;
    logic                            full_redraw_pending;
    logic [drt_pkg::COUNT_OUT_W-1:0] region_count;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_data;

    // Behavioral copy of the tracker state.
    drt_pkg::box_t dirty_list [DIRTY_SLOTS];
    int unsigned   dirty_count;
    bit            redraw_all;
    bit            tracking_on;

    tracker_status_t expected_status [$];
    int              mismatch_count;
    int              sent_items;
    int              burst_left;
    int              cycle_count;

    dirty_rectangle_tracker #(
        .MAX_REGIONS(DIRTY_SLOTS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .action             (action),
        .rect_x             (rect_x),
        .rect_y             (rect_y),
        .rect_width         (rect_width),
        .rect_height        (rect_height),
        .done               (done),
        .needs_draw         (needs_draw),
        .full_redraw_pending(full_redraw_pending),
        .region_count       (region_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_status.size());
            $display("status: fail");
            $finish;
        end
    end

    // Touching rectangles count as intersecting.
    function automatic bit rects_touch(input drt_pkg::box_t a, input drt_pkg::box_t b);
        return !(a.r < b.l || b.r < a.l || a.b < b.t || b.b < a.t);
    endfunction

    function automatic drt_pkg::box_t rect_span(input drt_pkg::box_t a,
                                                input drt_pkg::box_t b);
        drt_pkg::box_t u;
        u.l = (a.l < b.l) ? a.l : b.l;
        u.t = (a.t < b.t) ? a.t : b.t;
        u.r = (a.r > b.r) ? a.r : b.r;
        u.b = (a.b > b.b) ? a.b : b.b;
        return u;
    endfunction

    // Apply one command to the tracker copy and return the status it reports.
    function automatic tracker_status_t predict_tracker(input logic [2:0] act,
                                                       input drt_pkg::box_t nb);
        tracker_status_t st;
        drt_pkg::box_t   grown;
        int unsigned     i;
        st.needs_draw = 1'b0;
        grown = nb;
        case (act)
            drt_pkg::ACT_MARK:
            begin
                if (tracking_on && !redraw_all)
                begin
                    // Absorb touching entries; each absorption restarts the scan.
                    i = 0;
                    while (i < dirty_count)
                    begin
                        if (rects_touch(dirty_list[i], grown))
                        begin
                            grown = rect_span(dirty_list[i], grown);
                            dirty_count--;
                            dirty_list[i] = dirty_list[dirty_count];
                            i = 0;
                        end
                        else
                        begin
                            i++;
                        end
                    end
                    if (dirty_count < DIRTY_SLOTS)
                    begin
                        dirty_list[dirty_count] = grown;
                        dirty_count++;
                    end
                    else
                    begin
                        redraw_all = 1'b1;
                    end
                end
            end
            drt_pkg::ACT_CHECK:
            begin
                if (!tracking_on || redraw_all)
                begin
                    st.needs_draw = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < dirty_count; k++)
                    begin
                        if (rects_touch(dirty_list[k], nb))
                        begin
                            st.needs_draw = 1'b1;
                        end
                    end
                end
            end
            drt_pkg::ACT_INVALIDATE:
            begin
                redraw_all = 1'b1;
            end
            drt_pkg::ACT_INIT:
            begin
                dirty_count = 0;
                redraw_all  = 1'b1;
                tracking_on = 1'b0;
            end
            drt_pkg::ACT_CLEAR:
            begin
                dirty_count = 0;
                redraw_all  = 1'b0;
            end
            default:
            begin
            end
        endcase
        st.redraw_all = redraw_all;
        st.count = dirty_count[drt_pkg::COUNT_OUT_W-1:0];
        return st;
    endfunction

    // Send one command beat and record the status it should produce.
    task automatic send_command(input logic [2:0] act,
                                input logic [drt_pkg::COORD_W-1:0] x,
                                input logic [drt_pkg::COORD_W-1:0] y,
                                input logic [drt_pkg::COORD_W-1:0] w,
                                input logic [drt_pkg::COORD_W-1:0] h);
        drt_pkg::box_t nb;
        start       <= 1'b1;
        action      <= act;
        rect_x      <= x;
        rect_y      <= y;
        rect_width  <= w;
        rect_height <= h;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        nb.l = {1'b0, x};
        nb.t = {1'b0, y};
        nb.r = {1'b0, x} + {1'b0, w};
        nb.b = {1'b0, y} + {1'b0, h};
        sent_items++;
        expected_status.push_back(predict_tracker(act, nb));
    endtask

    // Sender pacing: bursts of back-to-back commands separated by random gaps.
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 5);
        end
    endtask

    // Wait until every expected beat has arrived and the block is idle.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_status.size() != 0)
        begin
            @(posedge clk);
        end
        while (busy)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_tracking(input bit enable);
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        tracking_on = enable;
        if (enable)
        begin
            redraw_all = 1'b1;
        end
    endtask

    function automatic logic [drt_pkg::COORD_W-1:0] wide_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COORD_MAX;
            default: return drt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    // Choose a rectangle according to the placement style of the phase.
    task automatic pick_rect(input place_mode_t mode,
                             output logic [drt_pkg::COORD_W-1:0] x,
                             output logic [drt_pkg::COORD_W-1:0] y,
                             output logic [drt_pkg::COORD_W-1:0] w,
                             output logic [drt_pkg::COORD_W-1:0] h);
        case (mode)
            PLACE_CLUSTER:
            begin
                x = drt_pkg::COORD_W'($urandom_range(0, 300));
                y = drt_pkg::COORD_W'($urandom_range(0, 300));
                w = drt_pkg::COORD_W'($urandom_range(0, 40));
                h = drt_pkg::COORD_W'($urandom_range(0, 40));
            end
            PLACE_GRID:
            begin
                // Cells 512 pixels apart keep rectangles in different cells disjoint.
                x = drt_pkg::COORD_W'($urandom_range(0, 15) * 512 + $urandom_range(0, 200));
                y = drt_pkg::COORD_W'($urandom_range(0, 15) * 512 + $urandom_range(0, 200));
                w = drt_pkg::COORD_W'($urandom_range(0, 250));
                h = drt_pkg::COORD_W'($urandom_range(0, 250));
            end
            default:
            begin
                x = wide_coord();
                y = wide_coord();
                w = wide_coord();
                h = wide_coord();
            end
        endcase
    endtask

    // Result checker: every strobed beat is matched against the oldest prediction.
    task automatic check_field(input string label,
                               input logic [drt_pkg::COUNT_OUT_W-1:0] want,
                               input logic [drt_pkg::COUNT_OUT_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        tracker_status_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_status.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat: expected none, actual %0d/%0d/%0d",
                         $time, needs_draw, full_redraw_pending, region_count);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("needs_draw", drt_pkg::COUNT_OUT_W'(want.needs_draw),
                            drt_pkg::COUNT_OUT_W'(needs_draw));
                check_field("full_redraw_pending", drt_pkg::COUNT_OUT_W'(want.redraw_all),
                            drt_pkg::COUNT_OUT_W'(full_redraw_pending));
                check_field("region_count", want.count, region_count);
            end
        end
    end

    // Tracking off and a pending full redraw both gate marks and checks.
    task automatic test_tracking_gates();
        send_command(drt_pkg::ACT_CHECK, 13'd10, 13'd10, 13'd4, 13'd4);
        pace_sender();
        send_command(drt_pkg::ACT_MARK, 13'd10, 13'd10, 13'd4, 13'd4);
        wait_idle();
        write_tracking(1'b1);
        send_command(drt_pkg::ACT_MARK, 13'd10, 13'd10, 13'd4, 13'd4);
        pace_sender();
        send_command(drt_pkg::ACT_CLEAR, 13'd0, 13'd0, 13'd0, 13'd0);
        pace_sender();
        send_command(drt_pkg::ACT_CHECK, 13'd10, 13'd10, 13'd4, 13'd4);
        pace_sender();
    endtask

    // Smallest and largest rectangles, exact edge contact and a near miss.
    task automatic test_edge_extremes();
        send_command(drt_pkg::ACT_MARK, 13'd0, 13'd0, 13'd0, 13'd0);
        pace_sender();
        send_command(drt_pkg::ACT_MARK, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        pace_sender();
        send_command(drt_pkg::ACT_CHECK, 13'd1, 13'd1, 13'd0, 13'd0);
        pace_sender();
        send_command(drt_pkg::ACT_CHECK, COORD_MAX, COORD_MAX, 13'd0, 13'd0);
        pace_sender();
        send_command(drt_pkg::ACT_CHECK, 13'd0, 13'd0, 13'd5, 13'd5);
        pace_sender();
    endtask

    // A mark that bridges two stored entries absorbs both across a scan restart.
    task automatic test_merge_restart();
        send_command(drt_pkg::ACT_CLEAR, 13'd0, 13'd0, 13'd0, 13'd0);
        pace_sender();
        send_command(drt_pkg::ACT_MARK, 13'd100, 13'd100, 13'd10, 13'd10);
        pace_sender();
        send_command(drt_pkg::ACT_MARK, 13'd200, 13'd100, 13'd10, 13'd10);
        pace_sender();
        send_command(drt_pkg::ACT_MARK, 13'd300, 13'd300, 13'd5, 13'd5);
        pace_sender();
        send_command(drt_pkg::ACT_MARK, 13'd110, 13'd105, 13'd90, 13'd0);
        pace_sender();
        send_command(drt_pkg::ACT_CHECK, 13'd150, 13'd104, 13'd0, 13'd0);
        pace_sender();
    endtask

    // Invalidate, clear, the unused codes and init.
    task automatic test_global_actions();
        send_command(drt_pkg::ACT_INVALIDATE, 13'd0, 13'd0, 13'd0, 13'd0);
        pace_sender();
        send_command(drt_pkg::ACT_CHECK, 13'd5000, 13'd5000, 13'd1, 13'd1);
        pace_sender();
        send_command(drt_pkg::ACT_CLEAR, 13'd0, 13'd0, 13'd0, 13'd0);
        pace_sender();
        send_command(ACT_RESERVED_LO, 13'd100, 13'd100, 13'd10, 13'd10);
        pace_sender();
        send_command(ACT_RESERVED_HI, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        pace_sender();
        send_command(drt_pkg::ACT_INIT, 13'd0, 13'd0, 13'd0, 13'd0);
        pace_sender();
        send_command(drt_pkg::ACT_CHECK, 13'd0, 13'd0, 13'd0, 13'd0);
        pace_sender();
    endtask

    // Random phases: each starts idle with a fresh enable setting, then runs
    // mostly marks and checks, clearing now and then so tracking resumes.
    task automatic test_random_traffic(input place_mode_t mode, input int share);
        int                          goal;
        int                          phase_goal;
        int                          roll;
        logic [2:0]                  act;
        logic [drt_pkg::COORD_W-1:0] x;
        logic [drt_pkg::COORD_W-1:0] y;
        logic [drt_pkg::COORD_W-1:0] w;
        logic [drt_pkg::COORD_W-1:0] h;
        goal = sent_items + share;
        while (sent_items < goal)
        begin
            wait_idle();
            write_tracking($urandom_range(0, 5) != 0);
            phase_goal = sent_items + $urandom_range(20, 80);
            while (sent_items < phase_goal && sent_items < goal)
            begin
                roll = $urandom_range(0, 99);
                if (redraw_all && roll < 40)
                    act = drt_pkg::ACT_CLEAR;
                else if (roll < 65)
                    act = drt_pkg::ACT_MARK;
                else if (roll < 88)
                    act = drt_pkg::ACT_CHECK;
                else if (roll < 93)
                    act = drt_pkg::ACT_INVALIDATE;
                else if (roll < 96)
                    act = drt_pkg::ACT_CLEAR;
                else if (roll < 99)
                    act = 3'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI));
                else
                    act = drt_pkg::ACT_INIT;
                pick_rect(mode, x, y, w, h);
                send_command(act, x, y, w, h);
                pace_sender();
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        action      <= drt_pkg::ACT_MARK;
        rect_x      <= '0;
        rect_y      <= '0;
        rect_width  <= '0;
        rect_height <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 1'b0;
        mismatch_count = 0;
        sent_items     = 0;
        burst_left     = 0;
        cycle_count    = 0;
        dirty_count    = 0;
        redraw_all     = 1'b1;
        tracking_on    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tracking_gates();
        test_edge_extremes();
        test_merge_restart();
        test_global_actions();
        test_random_traffic(PLACE_CLUSTER, 450);
        test_random_traffic(PLACE_GRID, 400);
        test_random_traffic(PLACE_WIDE, 250);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_status.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/drt_pkg.sv
hw/rtl/drt_ram.sv
hw/rtl/drt_box_unit.sv
hw/rtl/dirty_rectangle_tracker.sv
tb/tb.sv
